FILE: src/wswt_pkg.sv
// Shared types and constants for the working-set window tracker.
package wswt_pkg;

   // Fixed field widths of the streaming and register ports
   localparam int PAGE_W     = 16;
   localparam int TIME_W     = 16;
   localparam int SIZE_W     = 5;
   localparam int WS_W       = 5;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_PAD_W  = RSP_DATA_W - (TIME_W + SIZE_W + PAGE_W);
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register map, indexed by word
   localparam logic REG_WINDOW_SIZE = 1'b0;

   localparam logic [WS_W-1:0]   WINDOW_SIZE_RESET = 5'd6;
   localparam logic [TIME_W-1:0] TIME_MAX          = 16'hFFFF;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

FILE: src/wswt_ring.sv
// History ring of page references with a row of duplicate comparators.
module wswt_ring #(
   parameter int WINDOW_MAX = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(WINDOW_MAX)-1:0] wr_slot,
   input  logic [PAGE_BITS-1:0]          wr_page,
   input  logic [$clog2(WINDOW_MAX)-1:0] rd_slot,
   input  logic [WINDOW_MAX-1:0]         older_mask,
   output logic [PAGE_BITS-1:0]          rd_page,
   output logic                          rd_dup
);

   logic [PAGE_BITS-1:0]  entries_ff [WINDOW_MAX];
   logic [WINDOW_MAX-1:0] hit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_slot] <= wr_page;
      end
   end

   assign rd_page = entries_ff[rd_slot];

   // Compare the selected entry against every slot already scanned
   always_comb begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
         hit[j] = older_mask[j] && (entries_ff[j] == rd_page);
      end
   end

   assign rd_dup = |hit;

endmodule

FILE: src/working_set_window_tracker.sv
// Working-set window tracker: top level with sequencer, register port and output stage.
//
// Each request transaction carries one page reference (tdata) and a new-list flag (tuser).
// The block keeps the last window_size references in a ring; once a full window has been
// seen since the last new list, it returns one response transaction per distinct page of
// the window, oldest first appearance first, the final one marked by tlast. A reference
// that causes no responses leaves the block idle. Otherwise the item runs a scan pass
// over the effective window (window_size held to 1..WINDOW_MAX) that counts the distinct
// pages through a single row of comparators against the slots already scanned, then an
// emit pass that drives the output register, waits while the response side stalls, and
// stops at the slot of the last distinct page. req_tready is high only between items.
// The time index saturates at 65535. window_size is written over the register port at
// any address with bit 2 clear (0 to 3) and takes effect with the next reference.
module working_set_window_tracker #(
   parameter int WINDOW_MAX = 16,
   parameter int PAGE_BITS  = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [wswt_pkg::REQ_DATA_W-1:0]       req_tdata,  // [15:0] page
   input  logic [wswt_pkg::REQ_USER_W-1:0]       req_tuser,  // [0] new_list
   // response channel
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] time_index, [20:16] set_size, [36:21] member_page, [39:37] zero
   output logic [wswt_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,  // last_member
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [wswt_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [wswt_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [wswt_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   localparam int IDX_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_MAX - 1);

   // control state
   wswt_pkg::state_type               state_ff, state_in;
   logic [wswt_pkg::WS_W-1:0]         ws_ff, ws_in;
   logic [IDX_W-1:0]                  wp_ff, wp_in;
   logic [wswt_pkg::TIME_W-1:0]       seen_ff, seen_in;
   logic [IDX_W-1:0]                  pos_ff, pos_in;
   logic [IDX_W-1:0]                  start_ff, start_in;
   logic [CNT_W-1:0]                  step_ff, step_in;
   logic [CNT_W-1:0]                  w_ff, w_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [CNT_W-1:0]                  emitted_ff, emitted_in;
   logic [WINDOW_MAX-1:0]             scanned_ff, scanned_in;
   logic                              rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [wswt_pkg::TIME_W-1:0]       stamp_ff, stamp_in;
   logic [WINDOW_MAX-1:0]             first_ff, first_in;
   logic [wswt_pkg::TIME_W-1:0]       rsp_time_ff, rsp_time_in;
   logic [wswt_pkg::SIZE_W-1:0]       rsp_size_ff, rsp_size_in;
   logic [wswt_pkg::PAGE_W-1:0]       rsp_page_ff, rsp_page_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              accept;
   logic                              new_list;
   logic [IDX_W-1:0]                  wp_start;
   logic [IDX_W-1:0]                  wp_next;
   logic [wswt_pkg::TIME_W-1:0]       stamp;
   logic [CNT_W-1:0]                  w_eff;
   logic [IDX_W:0]                    start_sum;
   logic [IDX_W-1:0]                  start_slot;
   logic                              run_needed;
   logic [IDX_W-1:0]                  pos_next;
   logic                              out_free;
   logic                              load_out;
   logic                              last_out;
   logic                              csr_write;
   logic                              csr_reg_index;
   logic [PAGE_BITS-1:0]              ring_page;
   logic                              ring_dup;

   wswt_ring #(
      .WINDOW_MAX (WINDOW_MAX),
      .PAGE_BITS  (PAGE_BITS)
   ) u_ring (
      .clock      (clock),
      .wr_en      (accept),
      .wr_slot    (wp_start),
      .wr_page    (PAGE_BITS'(req_tdata)),
      .rd_slot    (pos_ff),
      .older_mask (scanned_ff),
      .rd_page    (ring_page),
      .rd_dup     (ring_dup)
   );

   // register port
   assign csr_pready    = 1'b1;
   assign csr_reg_index = csr_paddr[2];
   assign csr_write     = csr_psel && csr_penable && csr_pwrite && csr_pready
                          && (csr_reg_index == wswt_pkg::REG_WINDOW_SIZE);
   assign csr_prdata    = (csr_reg_index == wswt_pkg::REG_WINDOW_SIZE)
                          ? wswt_pkg::CSR_DATA_W'(ws_ff) : '0;
   assign ws_in         = csr_write ? csr_pwdata[wswt_pkg::WS_W-1:0] : ws_ff;

   // request side decode
   assign req_tready = (state_ff == wswt_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign new_list   = req_tuser[0];
   assign wp_start   = new_list ? '0 : wp_ff;
   assign wp_next    = (wp_start == LAST_SLOT) ? '0 : wp_start + 1'b1;
   assign stamp      = new_list ? '0 : seen_ff;

   // hold window size to 1..WINDOW_MAX
   always_comb begin
      if (ws_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (32'(ws_ff) > 32'(WINDOW_MAX)) begin
         w_eff = CNT_W'(WINDOW_MAX);
      end else begin
         w_eff = CNT_W'(ws_ff);
      end
   end

   assign start_sum  = {1'b0, wp_next} + (IDX_W+1)'(WINDOW_MAX) - (IDX_W+1)'(w_eff);
   assign start_slot = (start_sum >= (IDX_W+1)'(WINDOW_MAX))
                       ? IDX_W'(start_sum - (IDX_W+1)'(WINDOW_MAX))
                       : IDX_W'(start_sum);
   assign run_needed = ({1'b0, stamp} + 1'b1) >= (wswt_pkg::TIME_W+1)'(w_eff);

   assign pos_next   = (pos_ff == LAST_SLOT) ? '0 : pos_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign load_out   = (state_ff == wswt_pkg::ST_EMIT) && first_ff[pos_ff] && out_free;
   assign last_out   = (emitted_ff == count_ff - 1'b1);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      pos_in       = pos_ff;
      start_in     = start_ff;
      step_in      = step_ff;
      w_in         = w_ff;
      count_in     = count_ff;
      emitted_in   = emitted_ff;
      scanned_in   = scanned_ff;
      stamp_in     = stamp_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_last_in  = rsp_last_ff;

      // drop the output transaction once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wswt_pkg::ST_IDLE: begin
            if (accept) begin
               wp_in      = wp_next;
               seen_in    = (stamp == wswt_pkg::TIME_MAX) ? stamp : stamp + 1'b1;
               stamp_in   = stamp;
               w_in       = w_eff;
               start_in   = start_slot;
               pos_in     = start_slot;
               step_in    = '0;
               count_in   = '0;
               scanned_in = '0;
               if (run_needed) begin
                  state_in = wswt_pkg::ST_SCAN;
               end
            end
         end
         wswt_pkg::ST_SCAN: begin
            // mark first appearances, oldest slot first
            scanned_in[pos_ff] = 1'b1;
            first_in[pos_ff]   = !ring_dup;
            count_in           = count_ff + CNT_W'(!ring_dup);
            pos_in             = pos_next;
            step_in            = step_ff + 1'b1;
            if (step_ff == w_ff - 1'b1) begin
               state_in   = wswt_pkg::ST_EMIT;
               pos_in     = start_ff;
               step_in    = '0;
               emitted_in = '0;
            end
         end
         wswt_pkg::ST_EMIT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = stamp_ff;
               rsp_size_in  = wswt_pkg::SIZE_W'(count_ff);
               rsp_page_in  = wswt_pkg::PAGE_W'(ring_page);
               rsp_last_in  = last_out;
               emitted_in   = emitted_ff + 1'b1;
               pos_in       = pos_next;
               step_in      = step_ff + 1'b1;
               if (last_out) begin
                  state_in = wswt_pkg::ST_IDLE;
               end
            end else if (!first_ff[pos_ff]) begin
               // skip repeated pages
               pos_in  = pos_next;
               step_in = step_ff + 1'b1;
            end
         end
         default: begin
            state_in = wswt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wswt_pkg::ST_IDLE;
         ws_ff        <= wswt_pkg::WINDOW_SIZE_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         pos_ff       <= '0;
         start_ff     <= '0;
         step_ff      <= '0;
         w_ff         <= '0;
         count_ff     <= '0;
         emitted_ff   <= '0;
         scanned_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         step_ff      <= step_in;
         w_ff         <= w_in;
         count_ff     <= count_in;
         emitted_ff   <= emitted_in;
         scanned_ff   <= scanned_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stamp_ff    <= stamp_in;
      first_ff    <= first_in;
      rsp_time_ff <= rsp_time_in;
      rsp_size_ff <= rsp_size_in;
      rsp_page_ff <= rsp_page_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{wswt_pkg::RSP_PAD_W{1'b0}}, rsp_page_ff, rsp_size_ff, rsp_time_ff};

   // never emit more members than the scan counted
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wswt_pkg::ST_EMIT) |-> (emitted_ff < count_ff))
      else $error("emitted count reached set size while still emitting");

   // distinct count cannot exceed the window
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wswt_pkg::ST_IDLE) |-> (count_ff <= w_ff))
      else $error("set size above window");

   // slot walk stays inside the window
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wswt_pkg::ST_IDLE) |-> (step_ff < w_ff))
      else $error("slot walk ran past window");

   // last member ends the run
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load_out && last_out) |=> (state_ff == wswt_pkg::ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("run did not end after last member");

endmodule

FILE: bench/working_set_window_tracker_test.sv
// Self-checking testbench for the working-set window tracker: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module working_set_window_tracker_test;

   localparam int WIN_MAX       = 16;
   localparam int MAX_GAP       = 17;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int MAX_PRINTED   = 30;
   localparam int PHASE_REFS    = 24;

   localparam logic [wswt_pkg::CSR_ADDR_W-1:0] WINDOW_SIZE_ADDR =
      {wswt_pkg::REG_WINDOW_SIZE, 2'b00};
   localparam logic [wswt_pkg::CSR_ADDR_W-1:0] UNUSED_ADDR      = 3'd4;

   typedef struct packed {
      logic [wswt_pkg::PAGE_W-1:0] page;
      logic                        new_list;
   } page_ref_type;

   typedef struct packed {
      logic [wswt_pkg::TIME_W-1:0] stamp;
      logic [wswt_pkg::SIZE_W-1:0] set_size;
      logic [wswt_pkg::PAGE_W-1:0] page;
      logic                        is_last;
   } member_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [wswt_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic [wswt_pkg::REQ_USER_W-1:0] req_tuser   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b0;
   logic [wswt_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [wswt_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [wswt_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [wswt_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   working_set_window_tracker DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Predictor state
   logic [wswt_pkg::PAGE_W-1:0] page_ring [WIN_MAX];
   logic [$clog2(WIN_MAX)-1:0]  ring_wp       = '0;
   logic [wswt_pkg::TIME_W-1:0] refs_in_list  = '0;
   logic [wswt_pkg::WS_W-1:0]   window_mirror = wswt_pkg::WINDOW_SIZE_RESET;

   page_ref_type pending_refs[$];
   member_type   expected_members[$];

   bit send_idle = 1'b1;
   bit recv_idle = 1'b1;
   bit hold_arm  = 1'b0;
   bit hold_done = 1'b0;
   int send_wait = 0;
   int recv_wait = 0;

   int mismatches      = 0;
   int refs_taken      = 0;
   int results_checked = 0;
   int settings_used   = 0;
   int cycle_count     = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, expected_members.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Work out the run of distinct pages caused by one accepted reference.
   task automatic predict_reference(input logic [wswt_pkg::PAGE_W-1:0] page, input logic fresh);
      logic [wswt_pkg::TIME_W-1:0] stamp;
      logic [wswt_pkg::PAGE_W-1:0] distinct[$];
      logic [wswt_pkg::PAGE_W-1:0] slot_page;
      int                          span;
      int                          first_slot;
      bit                          dup;
      member_type                  m;
      if (fresh) begin
         ring_wp      = '0;
         refs_in_list = '0;
      end
      stamp = refs_in_list;
      if (refs_in_list != wswt_pkg::TIME_MAX)
         refs_in_list = refs_in_list + 1'b1;
      page_ring[ring_wp] = page;
      ring_wp            = ring_wp + 1'b1;
      refs_taken++;
      span = (window_mirror == 0) ? 1 : (window_mirror > WIN_MAX ? WIN_MAX : window_mirror);
      if (int'(stamp) + 1 < span)
         return;
      first_slot = (int'(ring_wp) + WIN_MAX - span) % WIN_MAX;
      for (int i = 0; i < span; i++) begin
         slot_page = page_ring[(first_slot + i) % WIN_MAX];
         dup       = 1'b0;
         foreach (distinct[j])
            if (distinct[j] == slot_page)
               dup = 1'b1;
         if (!dup)
            distinct.insert(distinct.size(), slot_page);
      end
      foreach (distinct[k]) begin
         m.stamp    = stamp;
         m.set_size = wswt_pkg::SIZE_W'(distinct.size());
         m.page     = distinct[k];
         m.is_last  = (k == distinct.size() - 1);
         expected_members.insert(expected_members.size(), m);
      end
   endtask

   task automatic check_result(input logic [wswt_pkg::RSP_DATA_W-1:0] data, input logic last);
      member_type e;
      if (expected_members.size() == 0) begin
         report_mismatch($sformatf("result %h with nothing expected", data));
         return;
      end
      e = expected_members.pop_front();
      results_checked++;
      if (data[wswt_pkg::TIME_W-1:0] !== e.stamp)
         report_mismatch($sformatf("time_index %0d, expected %0d",
                                   data[wswt_pkg::TIME_W-1:0], e.stamp));
      if (data[wswt_pkg::TIME_W +: wswt_pkg::SIZE_W] !== e.set_size)
         report_mismatch($sformatf("set_size %0d, expected %0d",
                                   data[wswt_pkg::TIME_W +: wswt_pkg::SIZE_W], e.set_size));
      if (data[wswt_pkg::TIME_W+wswt_pkg::SIZE_W +: wswt_pkg::PAGE_W] !== e.page)
         report_mismatch($sformatf("member_page %h, expected %h",
                                   data[wswt_pkg::TIME_W+wswt_pkg::SIZE_W +: wswt_pkg::PAGE_W],
                                   e.page));
      if (last !== e.is_last)
         report_mismatch($sformatf("last_member %b, expected %b", last, e.is_last));
   endtask

   // Request driver: present queued references, random gap after each transaction while send_idle is set.
   always @(posedge clock) begin
      page_ref_type nxt;
      int           wait_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
         send_wait  <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            predict_reference(req_tdata[wswt_pkg::PAGE_W-1:0], req_tuser[0]);
         wait_left = req_tvalid ? (send_idle ? $urandom_range(0, MAX_GAP) : 0) : send_wait;
         if (wait_left == 0 && pending_refs.size() != 0) begin
            nxt = pending_refs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= nxt.page;
            req_tuser  <= nxt.new_list;
            send_wait  <= 0;
         end else begin
            req_tvalid <= 1'b0;
            send_wait  <= (wait_left == 0) ? 0 : wait_left - 1;
         end
      end
   end

   // Response monitor and receiver: check each transaction, then stall at random while recv_idle is set.
   always @(posedge clock) begin
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_result(rsp_tdata, rsp_tlast);
         pause = recv_idle ? $urandom_range(0, MAX_GAP) : 0;
         rsp_tready <= (pause == 0);
         recv_wait  <= pause;
      end else if (recv_wait > 1) begin
         recv_wait <= recv_wait - 1;
      end else if (recv_wait == 1) begin
         recv_wait  <= 0;
         rsp_tready <= 1'b1;
      end else if (hold_arm && !hold_done) begin
         // hold off long enough for the block to back up into the request side
         recv_wait  <= LONG_HOLD;
         rsp_tready <= 1'b0;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_register(input logic [wswt_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [wswt_pkg::WS_W-1:0] value);
      logic [wswt_pkg::CSR_DATA_W-1:0] word;
      word = {$urandom} & ~wswt_pkg::CSR_DATA_W'(5'h1F);
      word = word | wswt_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == WINDOW_SIZE_ADDR) begin
         window_mirror = value;
         settings_used++;
      end
      @(negedge clock);
      // read back the window size through the same address
      if (addr == WINDOW_SIZE_ADDR && csr_prdata !== wswt_pkg::CSR_DATA_W'(window_mirror))
         report_mismatch($sformatf("window_size reads %0d, expected %0d",
                                   csr_prdata, window_mirror));
   endtask

   // Hold until every queued reference went out and every result came back.
   task automatic wait_quiet();
      @(negedge clock);
      while (pending_refs.size() != 0 || req_tvalid || expected_members.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_ref(input logic [wswt_pkg::PAGE_W-1:0] page, input logic fresh);
      page_ref_type r;
      r.page     = page;
      r.new_list = fresh;
      pending_refs.insert(pending_refs.size(), r);
   endtask

   // Mostly pages from a small pool so that windows repeat pages; some fully random.
   task automatic queue_random_refs(input int count, input int pool_size, input bit start_fresh);
      logic [wswt_pkg::PAGE_W-1:0] pool [WIN_MAX];
      logic [wswt_pkg::PAGE_W-1:0] page;
      foreach (pool[i])
         pool[i] = wswt_pkg::PAGE_W'($urandom);
      for (int n = 0; n < count; n++) begin
         page = ($urandom_range(0, 4) == 0) ? wswt_pkg::PAGE_W'($urandom)
                                            : pool[$urandom_range(0, pool_size - 1)];
         queue_ref(page, (n == 0 && start_fresh) || $urandom_range(0, 24) == 0);
      end
   endtask

   initial begin
      logic [wswt_pkg::WS_W-1:0] window_plan [10];
      window_plan = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd9, 5'd20, 5'd31, 5'd2, 5'd16, 5'd6};
      window_plan[7] = wswt_pkg::WS_W'($urandom_range(2, 15));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes of page, repeats, a clear in mid-list, at the reset window of 6.
      queue_ref(16'h0000, 1'b1);
      queue_ref(16'hFFFF, 1'b0);
      queue_ref(16'h0000, 1'b0);
      queue_ref(16'h1234, 1'b0);
      queue_ref(16'hFFFF, 1'b0);
      queue_ref(16'hABCD, 1'b0);
      repeat (6) queue_ref(16'h8000, 1'b0);
      queue_ref(16'h0001, 1'b0);
      queue_ref(16'h5555, 1'b1);
      repeat (4) queue_ref(16'h7FFF, 1'b0);
      queue_ref(16'hAAAA, 1'b0);
      wait_quiet();

      // Zero window acts as one, changed without a new list.
      write_register(WINDOW_SIZE_ADDR, 5'd0);
      queue_ref(16'hFFFF, 1'b0);
      queue_ref(16'h0000, 1'b0);
      wait_quiet();

      // Oversized window, then a write to an unmapped address that must be ignored.
      write_register(WINDOW_SIZE_ADDR, 5'd31);
      write_register(UNUSED_ADDR, 5'd2);
      for (int i = 0; i < 17; i++)
         queue_ref(wswt_pkg::PAGE_W'(i * 16'h0F0F), i == 0);
      wait_quiet();

      // Random phases over several window settings.
      foreach (window_plan[p]) begin
         write_register(WINDOW_SIZE_ADDR, window_plan[p]);
         if ($urandom_range(0, 3) == 0)
            write_register(UNUSED_ADDR, wswt_pkg::WS_W'($urandom));
         send_idle = (p != 4);
         recv_idle = (p != 4);
         queue_random_refs(PHASE_REFS, $urandom_range(1, WIN_MAX), $urandom_range(0, 1));
         if (p == 8) begin
            // keep offering while the receiver holds off
            send_idle = 1'b0;
            repeat (3) @(negedge clock);
            hold_arm = 1'b1;
         end
         wait_quiet();
      end

      $display("covered %0d references and %0d checked results over %0d window settings",
               refs_taken, results_checked, settings_used);
      $display("including random stalls on both sides and one long hold on the response side");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
